@@ sv/mrr_pkg.sv @@
package mrr_pkg;

  // Width of the candidate and witness ports.
  localparam int CAND_W = 63;

  typedef logic [1:0] verdict_t;

  localparam verdict_t VERDICT_TRIVIAL = 2'd0;
  localparam verdict_t VERDICT_WITNESS = 2'd1;
  localparam verdict_t VERDICT_PRIME   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_POW_CHECK,
    ST_POW_MUL,
    ST_POW_SQR,
    ST_SQ_CHECK,
    ST_SQ_MUL,
    ST_DONE
  } state_t;

endpackage

@@ sv/mrr_mulmod.sv @@
module mrr_mulmod #(
  parameter int W = 63
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] prod
);

  logic         busy;
  logic [W-1:0] ar;
  logic [W-1:0] br;
  logic [W-1:0] acc;

  logic [W:0]   acc_sum;
  logic [W:0]   acc_red;
  logic [W:0]   a_dbl;
  logic [W:0]   a_red;

  // Both operands stay below m, so one conditional subtract keeps each below m.
  assign acc_sum = {1'b0, acc} + {1'b0, ar};
  assign acc_red = (acc_sum >= {1'b0, m}) ? (acc_sum - {1'b0, m}) : acc_sum;
  assign a_dbl   = {ar, 1'b0};
  assign a_red   = (a_dbl >= {1'b0, m}) ? (a_dbl - {1'b0, m}) : a_dbl;

  assign done = busy && (br == '0);
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ar  <= a;
      br  <= b;
      acc <= '0;
    end else if (busy && (br != '0)) begin
      if (br[0]) begin
        acc <= acc_red[W-1:0];
      end
      ar <= a_red[W-1:0];
      br <= br >> 1;
    end
  end

endmodule

@@ sv/miller_rabin_round.sv @@
// Channel  Handshake           Fields
// -------  ------------------  ---------------------------------
// in       in_valid/in_ready   candidate[62:0], witness[62:0]
// out      out_valid/out_ready verdict[1:0]
//
// A trivially composite candidate goes from idle straight to the done state.
// Otherwise the witness is reduced bit by bit, then up to about 125 modular
// multiplications run on the single shift-add unit. Reset clears the sequencer
// and out_valid; in_ready is high only when the sequencer is idle. A result
// waiting on out_ready does not stop the next item from being accepted and
// worked on.
module miller_rabin_round #(
  parameter int VALUE_BITS = 63
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mrr_pkg::CAND_W-1:0]  candidate,
  input  logic [mrr_pkg::CAND_W-1:0]  witness,
  output logic                        out_valid,
  input  logic                        out_ready,
  output mrr_pkg::verdict_t           verdict
);
  import mrr_pkg::*;

  localparam int N  = VALUE_BITS;
  localparam int CW = $clog2(VALUE_BITS + 1);

  state_t state, state_next;

  logic [N-1:0]  cand;
  logic          trivial;

  logic [N-1:0]  p;
  logic [N-1:0]  pm1;
  logic [N-1:0]  wsh;
  logic [N-1:0]  rem;
  logic [N-1:0]  s;
  logic [N-1:0]  e;
  logic [N-1:0]  ex;
  logic [N-1:0]  base;
  logic [N-1:0]  x;
  logic [CW-1:0] cnt;
  verdict_t      vhold;

  logic [N:0]    rsh;
  logic [N:0]    rem_red;
  logic [N-1:0]  s_next;
  logic          sq_go;

  logic          mul_start;
  logic [N-1:0]  mul_a;
  logic [N-1:0]  mul_b;
  logic          mul_done;
  logic [N-1:0]  mul_prod;

  assign cand    = candidate[N-1:0];
  assign trivial = (cand[N-1:1] == '0) || ((cand != N'(2)) && !cand[0]);

  // Restoring reduction of the witness, one bit per cycle.
  assign rsh     = {rem, wsh[N-1]};
  assign rem_red = (rsh >= {1'b0, p}) ? (rsh - {1'b0, p}) : rsh;
  assign s_next  = s[0] ? s : (s >> 1);

  assign sq_go = (ex != pm1) && (x != N'(1)) && (x != pm1);

  assign in_ready = (state == ST_IDLE);

  mrr_mulmod #(
    .W(N)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .m    (p),
    .done (mul_done),
    .prod (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_a      = base;
    mul_b      = base;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = trivial ? ST_DONE : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (cnt == CW'(1)) begin
          state_next = ST_POW_CHECK;
        end
      end
      ST_POW_CHECK: begin
        if (e == '0) begin
          state_next = ST_SQ_CHECK;
        end else if (e[0]) begin
          mul_start  = 1'b1;
          mul_a      = x;
          state_next = ST_POW_MUL;
        end else begin
          mul_start  = 1'b1;
          state_next = ST_POW_SQR;
        end
      end
      ST_POW_MUL: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          state_next = ST_POW_SQR;
        end
      end
      ST_POW_SQR: begin
        if (mul_done) begin
          state_next = ST_POW_CHECK;
        end
      end
      ST_SQ_CHECK: begin
        if (sq_go) begin
          mul_start  = 1'b1;
          mul_a      = x;
          mul_b      = x;
          state_next = ST_SQ_MUL;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SQ_MUL: begin
        if (mul_done) begin
          state_next = ST_SQ_CHECK;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          p     <= cand;
          pm1   <= cand - N'(1);
          s     <= cand - N'(1);
          wsh   <= witness[N-1:0];
          rem   <= '0;
          cnt   <= CW'(VALUE_BITS);
          vhold <= VERDICT_TRIVIAL;
        end
      end
      ST_REDUCE: begin
        wsh <= wsh << 1;
        rem <= rem_red[N-1:0];
        s   <= s_next;
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          base <= rem_red[N-1:0];
          x    <= N'(1);
          e    <= s_next;
          ex   <= s_next;
        end
      end
      ST_POW_MUL: begin
        if (mul_done) begin
          x <= mul_prod;
        end
      end
      ST_POW_SQR: begin
        if (mul_done) begin
          base <= mul_prod;
          e    <= e >> 1;
        end
      end
      ST_SQ_CHECK: begin
        if (!sq_go) begin
          vhold <= ((x != pm1) && !ex[0]) ? VERDICT_WITNESS : VERDICT_PRIME;
        end
      end
      ST_SQ_MUL: begin
        if (mul_done) begin
          x  <= mul_prod;
          ex <= ex << 1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && (!out_valid || out_ready)) begin
      verdict <= vhold;
    end
  end

  // Anything past the trivial check works on an odd candidate or on 2.
  a_cand_ok: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POW_CHECK || state == ST_SQ_CHECK) |-> (p[0] || p == N'(2)))
    else $error("working on a trivially composite candidate");

  // The running value always stays reduced below the candidate.
  a_x_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POW_CHECK || state == ST_SQ_CHECK) |-> (x < p && base < p))
    else $error("running value not reduced");

  // The squaring exponent never passes candidate-1.
  a_ex_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQ_CHECK) |-> (ex <= pm1))
    else $error("squaring exponent overran");

  // The multiplier only finishes while the sequencer waits on it.
  a_mul_owner: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_POW_MUL || state == ST_POW_SQR || state == ST_SQ_MUL))
    else $error("multiplier finished outside a wait state");

endmodule
